// ----- rtl/fpa_pkg.sv -----
// Shared types, codes and widths of the Q24.8 fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int WORD_BITS   = 32;
    localparam int CMD_BITS    = 4;
    localparam int DVD_BITS    = WORD_BITS + FRAC_BITS;
    localparam int REM_BITS    = WORD_BITS + 1;
    localparam int PROD_BITS   = 2 * WORD_BITS;
    localparam int DIV_STEPS   = DVD_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_BITS-1:0] CMD_ADD  = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_SUB  = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_MUL  = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_DIV  = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_EQ   = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_NE   = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_LT   = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_LE   = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_GT   = 4'd8;
    localparam logic [CMD_BITS-1:0] CMD_GE   = 4'd9;
    localparam logic [CMD_BITS-1:0] CMD_MAX  = 4'd10;
    localparam logic [CMD_BITS-1:0] CMD_MIN  = 4'd11;
    localparam logic [CMD_BITS-1:0] CMD_FINT = 4'd12;
    localparam logic [CMD_BITS-1:0] CMD_TINT = 4'd13;
    localparam logic [CMD_BITS-1:0] CMD_INC  = 4'd14;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_LT, OP_LE,
        OP_GT, OP_GE, OP_MAX, OP_MIN, OP_FINT, OP_TINT, OP_INC, OP_NONE
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
    } item_t;

    typedef struct packed {
        op_t                  op;
        logic                 neg;
        logic [REM_BITS-1:0]  rem;
        logic [DVD_BITS-1:0]  quo;
        logic [WORD_BITS-1:0] dvs;
        logic [WORD_BITS-1:0] value;
        logic                 cmp;
        logic                 ovf;
        logic                 dbz;
    } work_t;

endpackage

// ----- rtl/fpa_front.sv -----
// Front stage: accept items and classify the command.
module fpa_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [fpa_pkg::CMD_BITS-1:0]          command,
    input  logic signed [fpa_pkg::WORD_BITS-1:0]  operand_a,
    input  logic signed [fpa_pkg::WORD_BITS-1:0]  operand_b,
    input  logic                                  q_full,
    output logic                                  item_vld,
    output fpa_pkg::item_t                        item
);

    logic           vld_reg;
    fpa_pkg::item_t item_reg;
    fpa_pkg::item_t item_next;

    assign full     = vld_reg && q_full;
    assign item_vld = vld_reg;
    assign item     = item_reg;

    always_comb
    begin
        item_next.a = operand_a;
        item_next.b = operand_b;
        unique case (command)
            fpa_pkg::CMD_ADD:  item_next.op = fpa_pkg::OP_ADD;
            fpa_pkg::CMD_SUB:  item_next.op = fpa_pkg::OP_SUB;
            fpa_pkg::CMD_MUL:  item_next.op = fpa_pkg::OP_MUL;
            fpa_pkg::CMD_DIV:  item_next.op = fpa_pkg::OP_DIV;
            fpa_pkg::CMD_EQ:   item_next.op = fpa_pkg::OP_EQ;
            fpa_pkg::CMD_NE:   item_next.op = fpa_pkg::OP_NE;
            fpa_pkg::CMD_LT:   item_next.op = fpa_pkg::OP_LT;
            fpa_pkg::CMD_LE:   item_next.op = fpa_pkg::OP_LE;
            fpa_pkg::CMD_GT:   item_next.op = fpa_pkg::OP_GT;
            fpa_pkg::CMD_GE:   item_next.op = fpa_pkg::OP_GE;
            fpa_pkg::CMD_MAX:  item_next.op = fpa_pkg::OP_MAX;
            fpa_pkg::CMD_MIN:  item_next.op = fpa_pkg::OP_MIN;
            fpa_pkg::CMD_FINT: item_next.op = fpa_pkg::OP_FINT;
            fpa_pkg::CMD_TINT: item_next.op = fpa_pkg::OP_TINT;
            fpa_pkg::CMD_INC:  item_next.op = fpa_pkg::OP_INC;
            default:           item_next.op = fpa_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (!full)
        begin
            vld_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!full && push)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/fpa_queue.sv -----
// Small queue between the front and back stages.
module fpa_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  fpa_pkg::item_t wr_item,
    output logic           q_full,
    input  logic           rd_en,
    output fpa_pkg::item_t rd_item,
    output logic           q_vld
);

    localparam int PTR_W = (fpa_pkg::QUEUE_DEPTH > 1) ? $clog2(fpa_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(fpa_pkg::QUEUE_DEPTH + 1);

    fpa_pkg::item_t   mem_reg [fpa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (cnt_reg == CNT_W'(fpa_pkg::QUEUE_DEPTH));
    assign q_vld   = (cnt_reg != '0);
    assign rd_item = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_vld;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fpa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fpa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/fpa_back.sv -----
// Back stage: execution pipeline with the divider steps and the result register.
module fpa_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 head_vld,
    input  fpa_pkg::item_t                       head,
    output logic                                 take,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [fpa_pkg::WORD_BITS-1:0] value,
    output logic                                 compare_true,
    output logic                                 overflow,
    output logic                                 divide_by_zero
);

    localparam int W = fpa_pkg::WORD_BITS;
    localparam int F = fpa_pkg::FRAC_BITS;
    localparam int D = fpa_pkg::DVD_BITS;
    localparam int P = fpa_pkg::PROD_BITS;
    localparam int N = fpa_pkg::DIV_STEPS;

    logic                  vld_reg [N+1];
    fpa_pkg::work_t        stage_reg [N+1];
    fpa_pkg::work_t        stage_next [N+1];
    logic                  out_vld_reg;
    fpa_pkg::work_t        out_reg;
    fpa_pkg::work_t        out_next;
    logic                  adv;

    function automatic fpa_pkg::work_t entry(input fpa_pkg::item_t it);
        fpa_pkg::work_t   w;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic [W:0]       s;
        logic [D-1:0]     fi;
        logic [W-1:0]     ti;
        logic signed [P-1:0] prod;
        a = it.a;
        b = it.b;
        w = '0;
        w.op = it.op;
        unique case (it.op)
            fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC:
            begin
                if (it.op == fpa_pkg::OP_ADD)
                    s = {a[W-1], a} + {b[W-1], b};
                else if (it.op == fpa_pkg::OP_SUB)
                    s = {a[W-1], a} - {b[W-1], b};
                else
                    s = {a[W-1], a} + (W+1)'(1);
                w.value = s[W-1:0];
                w.ovf   = s[W] ^ s[W-1];
            end
            fpa_pkg::OP_MUL:
            begin
                prod = a * b;
                w.rem = fpa_pkg::REM_BITS'(prod[P-1:D]);
                w.quo = prod[D-1:0];
            end
            fpa_pkg::OP_DIV:
            begin
                w.dbz = (b == '0);
                w.neg = a[W-1] ^ b[W-1];
                w.quo = {(a[W-1] ? W'(-a) : W'(a)), {F{1'b0}}};
                w.dvs = b[W-1] ? W'(-b) : W'(b);
            end
            fpa_pkg::OP_EQ:  w.cmp = (a == b);
            fpa_pkg::OP_NE:  w.cmp = (a != b);
            fpa_pkg::OP_LT:  w.cmp = (a < b);
            fpa_pkg::OP_LE:  w.cmp = (a <= b);
            fpa_pkg::OP_GT:  w.cmp = (a > b);
            fpa_pkg::OP_GE:  w.cmp = (a >= b);
            fpa_pkg::OP_MAX: w.value = (a > b) ? a : b;
            fpa_pkg::OP_MIN: w.value = (a < b) ? a : b;
            fpa_pkg::OP_FINT:
            begin
                fi = {a, {F{1'b0}}};
                w.value = fi[W-1:0];
                w.ovf   = (fi[D-1:W-1] != {(F+1){fi[W-1]}});
            end
            fpa_pkg::OP_TINT:
            begin
                ti = W'(a >>> F);
                w.value = ti + W'(a[W-1] && (a[F-1:0] != '0));
            end
            default: w.op = fpa_pkg::OP_NONE;
        endcase
        return w;
    endfunction

    function automatic fpa_pkg::work_t step(input fpa_pkg::work_t w, input logic first);
        fpa_pkg::work_t   r;
        logic [W:0]       t;
        logic signed [P-1:0] p;
        logic signed [P-1:0] q;
        r = w;
        if (w.op == fpa_pkg::OP_DIV && !w.dbz)
        begin
            t = {w.rem[W-1:0], w.quo[D-1]};
            if (t >= {1'b0, w.dvs})
            begin
                r.rem = fpa_pkg::REM_BITS'(t - {1'b0, w.dvs});
                r.quo = {w.quo[D-2:0], 1'b1};
            end
            else
            begin
                r.rem = fpa_pkg::REM_BITS'(t);
                r.quo = {w.quo[D-2:0], 1'b0};
            end
        end
        else if (first && w.op == fpa_pkg::OP_MUL)
        begin
            p = {w.rem[P-D-1:0], w.quo};
            q = (p >>> F) + $signed(P'(p[P-1] && (p[F-1:0] != '0)));
            r.value = q[W-1:0];
            r.ovf   = (q[P-1:W-1] != {(P-W+1){q[W-1]}});
        end
        return r;
    endfunction

    function automatic fpa_pkg::work_t finish(input fpa_pkg::work_t w);
        fpa_pkg::work_t r;
        logic [D:0]     q;
        r = w;
        if (w.op == fpa_pkg::OP_DIV && !w.dbz)
        begin
            q = w.neg ? -{1'b0, w.quo} : {1'b0, w.quo};
            r.value = q[W-1:0];
            r.ovf   = (q[D:W-1] != {(D-W+2){q[W-1]}});
        end
        return r;
    endfunction

    assign adv            = !out_vld_reg || pop;
    assign take           = adv;
    assign empty          = !out_vld_reg;
    assign value          = out_reg.value;
    assign compare_true   = out_reg.cmp;
    assign overflow       = out_reg.ovf;
    assign divide_by_zero = out_reg.dbz;

    always_comb
    begin
        stage_next[0] = entry(head);
        for (int i = 1; i <= N; i++)
        begin
            stage_next[i] = step(stage_reg[i-1], i == 1);
        end
        out_next = finish(stage_reg[N]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= head_vld;
            for (int i = 1; i <= N; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_vld_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= N; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
            out_reg <= out_next;
        end
    end

endmodule

// ----- rtl/fixed_point_q24_8_alu_top.sv -----
// Top level of the signed Q24.8 fixed-point ALU.
// Usage:
//   Input channel: drive command, operand_a, operand_b and raise push; the
//   item is taken on a clock edge where push is high and full is low.
//   Result channel: while empty is low, value, compare_true, overflow and
//   divide_by_zero show the oldest result; raise pop to take it.
// Throughput: one item per cycle, sustained while pop is held high, with items of any command mixed.
// Path: every command passes the front register, the queue, the entry stage, the
//   divider (one quotient bit per stage over 40 stages) and the result register.
// Stalls: when pop stays low, the execution pipeline holds; the two-entry
//   queue and the front register then fill and full rises. No item is lost.
// Reset: rst_n low clears all valid state at once; the block is empty and
//   ready as soon as rst_n is released.
module fixed_point_q24_8_alu_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [fpa_pkg::CMD_BITS-1:0]         command,
    input  logic signed [fpa_pkg::WORD_BITS-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_BITS-1:0] operand_b,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [fpa_pkg::WORD_BITS-1:0] value,
    output logic                                 compare_true,
    output logic                                 overflow,
    output logic                                 divide_by_zero
);

    logic           f_vld;
    fpa_pkg::item_t f_item;
    logic           q_full;
    logic           q_vld;
    fpa_pkg::item_t q_item;
    logic           take;

    fpa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_full    (q_full),
        .item_vld  (f_vld),
        .item      (f_item)
    );

    fpa_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_vld),
        .wr_item (f_item),
        .q_full  (q_full),
        .rd_en   (take),
        .rd_item (q_item),
        .q_vld   (q_vld)
    );

    fpa_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_vld       (q_vld),
        .head           (q_item),
        .take           (take),
        .empty          (empty),
        .pop            (pop),
        .value          (value),
        .compare_true   (compare_true),
        .overflow       (overflow),
        .divide_by_zero (divide_by_zero)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU: directed and random items.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fpa_pkg::CMD_BITS-1:0] CMD_UNUSED = 4'd15;

    typedef struct {
        logic signed [31:0] value;
        logic               cmp;
        logic               ovf;
        logic               dbz;
    } alu_result_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [fpa_pkg::CMD_BITS-1:0] command;
    logic signed [fpa_pkg::WORD_BITS-1:0] operand_a;
    logic signed [fpa_pkg::WORD_BITS-1:0] operand_b;
    logic empty;
    logic pop;
    logic signed [fpa_pkg::WORD_BITS-1:0] value;
    logic compare_true;
    logic overflow;
    logic divide_by_zero;

    alu_result_t pending_results[$];
    int  mismatch_count;
    int  idle_cycles;
    bit  hold_pop;
    bit  timed_out;

    fixed_point_q24_8_alu_top u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .empty          (empty),
        .pop            (pop),
        .value          (value),
        .compare_true   (compare_true),
        .overflow       (overflow),
        .divide_by_zero (divide_by_zero)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] wrap_q(input logic signed [71:0] exact, inout logic ovf);
        if (exact > 72'sd2147483647 || exact < -72'sd2147483648)
        begin
            ovf = 1'b1;
        end
        return exact[31:0];
    endfunction

    function automatic alu_result_t compute_alu(input logic [3:0] cmd,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        alu_result_t r;
        logic signed [71:0] wa;
        logic signed [71:0] wb;
        logic signed [71:0] scale;
        logic               ovf;
        wa = a;
        wb = b;
        scale = 72'sd256;
        ovf = 1'b0;
        r.value = '0;
        r.cmp = 1'b0;
        r.ovf = 1'b0;
        r.dbz = 1'b0;
        case (cmd)
            fpa_pkg::CMD_ADD:  r.value = wrap_q(wa + wb, ovf);
            fpa_pkg::CMD_SUB:  r.value = wrap_q(wa - wb, ovf);
            fpa_pkg::CMD_MUL:  r.value = wrap_q((wa * wb) / scale, ovf);
            fpa_pkg::CMD_DIV:
            begin
                if (b == 0)
                begin
                    r.dbz = 1'b1;
                end
                else
                begin
                    r.value = wrap_q((wa * scale) / wb, ovf);
                end
            end
            fpa_pkg::CMD_EQ:   r.cmp = (a == b);
            fpa_pkg::CMD_NE:   r.cmp = (a != b);
            fpa_pkg::CMD_LT:   r.cmp = (a < b);
            fpa_pkg::CMD_LE:   r.cmp = (a <= b);
            fpa_pkg::CMD_GT:   r.cmp = (a > b);
            fpa_pkg::CMD_GE:   r.cmp = (a >= b);
            fpa_pkg::CMD_MAX:  r.value = (a > b) ? a : b;
            fpa_pkg::CMD_MIN:  r.value = (a < b) ? a : b;
            fpa_pkg::CMD_FINT: r.value = wrap_q(wa * scale, ovf);
            fpa_pkg::CMD_TINT: r.value = wrap_q(wa / scale, ovf);
            fpa_pkg::CMD_INC:  r.value = wrap_q(wa + 72'sd1, ovf);
            default:           r.value = '0;
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return ($urandom_range(0, 2000) - 1000) << 8;
            4: return $urandom_range(0, 65535) - 32768;
            5: return $signed($urandom()) >>> $urandom_range(0, 24);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input logic [3:0] cmd, input logic [31:0] a, input logic [31:0] b,
                             input bit use_gap);
        int gap;
        gap = use_gap ? gap_length() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap)
            begin
                @(posedge clk);
            end
        end
        push <= 1'b1;
        command <= cmd;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        pending_results.push_back(compute_alu(cmd, a, b));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_extremes();
        logic [31:0] edge_vals[6];
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'h1};
        send_item(fpa_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h1, 0);
        send_item(fpa_pkg::CMD_SUB, 32'h8000_0000, 32'h1, 0);
        send_item(fpa_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_item(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0);
        send_item(fpa_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h1, 0);
        send_item(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_item(fpa_pkg::CMD_DIV, 32'h1234_5678, 32'h0, 0);
        send_item(fpa_pkg::CMD_DIV, 32'hFFFF_FF01, 32'h300, 0);
        send_item(fpa_pkg::CMD_FINT, 32'h0080_0000, 32'hFFFF_FFFF, 0);
        send_item(fpa_pkg::CMD_TINT, 32'hFFFF_FF01, 32'h0, 0);
        send_item(fpa_pkg::CMD_TINT, 32'h8000_0000, 32'h0, 0);
        send_item(fpa_pkg::CMD_INC, 32'h7FFF_FFFF, 32'h0, 0);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        for (int c = fpa_pkg::CMD_EQ; c <= fpa_pkg::CMD_MIN; c++)
        begin
            send_item(c[3:0], edge_vals[c % 6], edge_vals[(c + 1) % 6], 0);
        end
        send_item(fpa_pkg::CMD_EQ, 32'h5, 32'h5, 0);
        send_item(fpa_pkg::CMD_LE, 32'h5, 32'h5, 0);
        send_item(fpa_pkg::CMD_GE, 32'h5, 32'h5, 0);
    endtask

    task automatic test_random(input int count);
        logic [3:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(0, 49) == 0) ? CMD_UNUSED : 4'($urandom_range(0, 14));
            send_item(cmd, pick_operand(), ($urandom_range(0, 19) == 0) ? 32'h0 : pick_operand(),
                      1);
        end
    endtask

    task automatic test_back_pressure();
        fork
            begin
                hold_pop <= 1'b1;
                repeat (200)
                begin
                    @(posedge clk);
                end
                hold_pop <= 1'b0;
            end
            begin
                for (int i = 0; i < 80; i++)
                begin
                    send_item(4'($urandom_range(0, 14)), $urandom(), $urandom(), 0);
                end
            end
        join
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        command = '0;
        operand_a = '0;
        operand_b = '0;
        hold_pop = 1'b0;
        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        drain_results();
        test_random(300);
        test_back_pressure();
        test_random(250);
        drain_results();
        repeat (50)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && !timed_out)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial
    begin
        int gap;
        pop = 1'b0;
        gap = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                gap = gap_length();
            end
            else if (gap > 0)
            begin
                gap--;
            end
            pop <= !hold_pop && gap == 0;
        end
    end

    initial
    begin
        alu_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected item: value %h", value);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (value !== want.value || compare_true !== want.cmp
                        || overflow !== want.ovf || divide_by_zero !== want.dbz)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                     want.value, want.cmp, want.ovf, want.dbz,
                                     value, compare_true, overflow, divide_by_zero);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        timed_out = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= 2000)
            begin
                timed_out = 1'b1;
                $display("testbench: done, errors");
                $finish;
            end
        end
    end
endmodule
